// ===== rtl/core/bprq_pkg.sv =====
// Shared types and codes of the bitmap priority run queue.
`default_nettype none

package bprq_pkg;

    // Fixed field widths of the command and result words
    localparam int TASK_W = 6;
    localparam int PRIO_W = 5;
    localparam int MAP_W  = 32;

    // Largest task table and level count that the field widths can address
    localparam int MAX_TASKS  = 2 ** TASK_W;
    localparam int MAX_LEVELS = 2 ** PRIO_W;

    typedef enum logic [1:0] {
        CMD_PUT = 2'd0,
        CMD_GET = 2'd1,
        CMD_DEL = 2'd2,
        CMD_NOP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_QUEUED     = 2'd2,
        ST_NOT_QUEUED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT_WR,
        S_GET_HEAD,
        S_DEL_LVL,
        S_DEL_WR
    } state_t;

    typedef struct packed {
        cmd_t              command;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [TASK_W-1:0] task_out;
        logic [PRIO_W-1:0] out_priority;
        logic [MAP_W-1:0]  nonempty_levels;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/bprq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and read port that holds its data while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_priority_run_queue.sv =====
// Top level of the bitmap priority run queue.
// Usage:
//   A command word (put, get, delete) is taken at a rising edge with start high
//   and busy low. Each command gives exactly one result word, shown on rsp for
//   one cycle with done high; the receiver must take it then.
//   Put appends a task to the FIFO of its level, get pops the head of the
//   lowest-numbered non-empty level, delete unlinks a task from its level.
// Sequencing:
//   Put reads the level table, then writes it and the link tables; get reads
//   the level table, then the head task's links, then writes back; delete
//   reads the task's level and links, then that level's head and tail, then
//   writes back. The result word is registered with the write-back. Rejected
//   commands (task queued or not queued, empty queue, unused code) give their
//   result straight from idle. Each table is a RAM with registered read data.
//   A new command can be taken in the cycle its predecessor's result shows.
// Reset:
//   Clears the level bitmap and the queued flags, so all levels are empty.
//   The RAM contents need no clearing; no entry's value is used before it is written.
`default_nettype none

module bitmap_priority_run_queue #(
    parameter int LEVELS = 32,
    parameter int TASKS  = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire bprq_pkg::req_t req,
    output logic               busy,
    output logic               done,
    output bprq_pkg::rsp_t     rsp
);

    import bprq_pkg::*;

    // Levels and tasks that the command fields can reach
    localparam int NL = (LEVELS < MAX_LEVELS) ? LEVELS : MAX_LEVELS;
    localparam int NT = (TASKS < MAX_TASKS) ? TASKS : MAX_TASKS;
    localparam int LW = $clog2(NL);
    localparam int TW = $clog2(NT);

    typedef struct packed {
        logic [TW-1:0] head;
        logic [TW-1:0] tail;
    } lvl_ent_t;

    // Control and status registers
    state_t        state_reg, state_next;
    logic [TW-1:0] t_reg, t_next;
    logic [LW-1:0] lv_reg, lv_next;
    logic          get_reg, get_next;
    logic [NL-1:0] bitmap_reg, bitmap_next;
    logic [NT-1:0] queued_reg, queued_next;
    logic          done_reg, done_next;
    rsp_t          rsp_reg, rsp_next;

    // RAM ports
    logic          lvl_we, lvl_re;
    logic [LW-1:0] lvl_waddr, lvl_raddr;
    lvl_ent_t      lvl_wdata, lvl_rdata;
    logic          nxt_we, prv_we, lev_we, task_re;
    logic [TW-1:0] nxt_waddr, prv_waddr, lev_waddr, task_raddr;
    logic [TW-1:0] nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;
    logic [LW-1:0] lev_wdata, lev_rdata;

    // Decoded command fields
    logic [TW-1:0] t_in;
    logic          t_ok;
    logic [LW-1:0] pr_in;
    logic [LW-1:0] lv_low;
    logic          hit, is_head, is_tail;

    assign t_in  = TW'(req.task_id);
    assign t_ok  = int'(req.task_id) < TASKS;
    assign pr_in = (int'(req.priority_req) >= NL) ? LW'(NL - 1) : LW'(req.priority_req);

    // Find the lowest non-empty level
    always_comb
    begin
        lv_low = '0;
        for (int i = NL - 1; i >= 0; i--)
        begin
            if (bitmap_reg[i])
            begin
                lv_low = LW'(i);
            end
        end
    end

    assign hit     = bitmap_reg[lv_reg];
    assign is_head = (lvl_rdata.head == t_reg);
    assign is_tail = (lvl_rdata.tail == t_reg);

    // Head and tail of each level
    bprq_ram #(.WIDTH(2 * TW), .DEPTH(NL)) u_lvl_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .re    (lvl_re),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

    // Forward links of each task
    bprq_ram #(.WIDTH(TW), .DEPTH(NT)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .re    (task_re),
        .raddr (task_raddr),
        .rdata (nxt_rdata)
    );

    // Backward links of each task
    bprq_ram #(.WIDTH(TW), .DEPTH(NT)) u_prv_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .re    (task_re),
        .raddr (task_raddr),
        .rdata (prv_rdata)
    );

    // Level of each queued task
    bprq_ram #(.WIDTH(LW), .DEPTH(NT)) u_lev_ram (
        .clk   (clk),
        .we    (lev_we),
        .waddr (lev_waddr),
        .wdata (lev_wdata),
        .re    (task_re),
        .raddr (task_raddr),
        .rdata (lev_rdata)
    );

    // Sequence each command through its reads and write-back
    always_comb
    begin
        state_next  = state_reg;
        t_next      = t_reg;
        lv_next     = lv_reg;
        get_next    = get_reg;
        bitmap_next = bitmap_reg;
        queued_next = queued_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;

        lvl_we     = 1'b0;
        lvl_re     = 1'b0;
        lvl_waddr  = lv_reg;
        lvl_raddr  = pr_in;
        lvl_wdata  = lvl_rdata;
        nxt_we     = 1'b0;
        prv_we     = 1'b0;
        lev_we     = 1'b0;
        task_re    = 1'b0;
        nxt_waddr  = t_reg;
        prv_waddr  = t_reg;
        lev_waddr  = t_reg;
        task_raddr = t_in;
        nxt_wdata  = t_reg;
        prv_wdata  = t_reg;
        lev_wdata  = lv_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req.command)
                        CMD_PUT:
                        begin
                            if (!t_ok || queued_reg[t_in])
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{status: t_ok ? ST_QUEUED : ST_NOT_QUEUED,
                                              task_out: '0, out_priority: '0,
                                              nonempty_levels: MAP_W'(bitmap_reg)};
                            end
                            else
                            begin
                                lvl_re     = 1'b1;
                                lvl_raddr  = pr_in;
                                t_next     = t_in;
                                lv_next    = pr_in;
                                state_next = S_PUT_WR;
                            end
                        end
                        CMD_GET:
                        begin
                            if (bitmap_reg == '0)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{status: ST_EMPTY, task_out: '0,
                                              out_priority: '0,
                                              nonempty_levels: MAP_W'(bitmap_reg)};
                            end
                            else
                            begin
                                lvl_re     = 1'b1;
                                lvl_raddr  = lv_low;
                                lv_next    = lv_low;
                                get_next   = 1'b1;
                                state_next = S_GET_HEAD;
                            end
                        end
                        CMD_DEL:
                        begin
                            if (!t_ok || !queued_reg[t_in])
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{status: ST_NOT_QUEUED, task_out: '0,
                                              out_priority: '0,
                                              nonempty_levels: MAP_W'(bitmap_reg)};
                            end
                            else
                            begin
                                task_re    = 1'b1;
                                task_raddr = t_in;
                                t_next     = t_in;
                                get_next   = 1'b0;
                                state_next = S_DEL_LVL;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{status: ST_OK, task_out: '0, out_priority: '0,
                                          nonempty_levels: MAP_W'(bitmap_reg)};
                        end
                    endcase
                end
            end

            S_PUT_WR:
            begin
                // Link behind the old tail, or open the level
                lvl_we    = 1'b1;
                lvl_waddr = lv_reg;
                if (hit)
                begin
                    lvl_wdata = '{head: lvl_rdata.head, tail: t_reg};
                    nxt_we    = 1'b1;
                    nxt_waddr = lvl_rdata.tail;
                    nxt_wdata = t_reg;
                    prv_we    = 1'b1;
                    prv_waddr = t_reg;
                    prv_wdata = lvl_rdata.tail;
                end
                else
                begin
                    lvl_wdata           = '{head: t_reg, tail: t_reg};
                    bitmap_next[lv_reg] = 1'b1;
                end
                lev_we             = 1'b1;
                lev_waddr          = t_reg;
                lev_wdata          = lv_reg;
                queued_next[t_reg] = 1'b1;
                done_next          = 1'b1;
                rsp_next           = '{status: ST_OK, task_out: '0, out_priority: '0,
                                       nonempty_levels: MAP_W'(bitmap_next)};
                state_next         = S_IDLE;
            end

            S_GET_HEAD:
            begin
                // Head of the chosen level becomes the task to unlink
                t_next     = lvl_rdata.head;
                task_re    = 1'b1;
                task_raddr = lvl_rdata.head;
                state_next = S_DEL_WR;
            end

            S_DEL_LVL:
            begin
                lv_next    = lev_rdata;
                lvl_re     = 1'b1;
                lvl_raddr  = lev_rdata;
                state_next = S_DEL_WR;
            end

            S_DEL_WR:
            begin
                // Unlink the task; drop the level when it was the only one
                if (is_head && is_tail)
                begin
                    bitmap_next[lv_reg] = 1'b0;
                end
                else
                begin
                    lvl_we    = is_head || is_tail;
                    lvl_waddr = lv_reg;
                    lvl_wdata = '{head: is_head ? nxt_rdata : lvl_rdata.head,
                                  tail: is_tail ? prv_rdata : lvl_rdata.tail};
                    nxt_we    = !is_head;
                    nxt_waddr = prv_rdata;
                    nxt_wdata = nxt_rdata;
                    prv_we    = !is_tail;
                    prv_waddr = nxt_rdata;
                    prv_wdata = prv_rdata;
                end
                queued_next[t_reg] = 1'b0;
                done_next          = 1'b1;
                rsp_next           = '{status: ST_OK,
                                       task_out: get_reg ? TASK_W'(t_reg) : '0,
                                       out_priority: get_reg ? PRIO_W'(lv_reg) : '0,
                                       nonempty_levels: MAP_W'(bitmap_next)};
                state_next         = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            bitmap_reg <= '0;
            queued_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bitmap_reg <= bitmap_next;
            queued_reg <= queued_next;
            done_reg   <= done_next;
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        lv_reg  <= lv_next;
        get_reg <= get_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bprq_chk.sv =====
// Port-level assertions of the bitmap priority run queue, bound to the top level.
`default_nettype none

module bprq_chk (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          done,
    input wire bprq_pkg::req_t req,
    input wire bprq_pkg::rsp_t rsp
);

    import bprq_pkg::*;

    cmd_t last_cmd_reg;

    // Hold the command of the last accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cmd_reg <= CMD_NOP;
        end
        else if (start && !busy)
        begin
            last_cmd_reg <= req.command;
        end
    end

    // An empty report only answers a get, and then no level is marked
    a_empty_get : assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == ST_EMPTY |-> last_cmd_reg == CMD_GET && rsp.nonempty_levels == '0)
        else $error("empty status without get or with levels marked");

    // Already-queued is only reported for a put
    a_queued_put : assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == ST_QUEUED |-> last_cmd_reg == CMD_PUT)
        else $error("already-queued status for a command other than put");

    // Only a successful get carries a task and level
    a_task_zero : assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != ST_OK || last_cmd_reg != CMD_GET)
        |-> rsp.task_out == '0 && rsp.out_priority == '0)
        else $error("task or level reported outside a successful get");

    // A get serves the lowest level, so no lower level remains marked
    a_lowest_level : assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == ST_OK && last_cmd_reg == CMD_GET
        |-> (rsp.nonempty_levels & ((32'd1 << rsp.out_priority) - 32'd1)) == 32'd0)
        else $error("get skipped a lower non-empty level");

endmodule

bind bitmap_priority_run_queue bprq_chk u_bprq_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .req   (req),
    .rsp   (rsp)
);

`default_nettype wire

// ===== dv/tb_bitmap_priority_run_queue.sv =====
// Self-checking testbench for the bitmap priority run queue: directed and random commands.
`timescale 1ns / 1ps

module tb_bitmap_priority_run_queue;

    import bprq_pkg::*;

    localparam int LEVELS     = 32;
    localparam int TASKS      = 64;
    localparam int STALL_LIMIT = 500;
    localparam int PHASE_ITEMS = 534;

    // Track the queue contents and hold the results they imply
    class run_queue_scoreboard;
        logic [MAP_W-1:0]  level_map;
        logic [TASK_W-1:0] head_of [LEVELS];
        logic [TASK_W-1:0] tail_of [LEVELS];
        logic [TASK_W-1:0] next_of [TASKS];
        logic [TASK_W-1:0] prev_of [TASKS];
        logic [PRIO_W-1:0] level_of [TASKS];
        bit                queued [TASKS];
        rsp_t              pending_results [$];
        int errors, n_put, n_get, n_del, n_nop, n_rejected, queued_count, peak_queued;

        function new();
            level_map = '0;
            foreach (queued[i]) queued[i] = 1'b0;
            foreach (next_of[i])
            begin
                next_of[i]  = '0;
                prev_of[i]  = '0;
                level_of[i] = '0;
            end
            foreach (head_of[i])
            begin
                head_of[i] = '0;
                tail_of[i] = '0;
            end
        endfunction

        // Pick a task in the wanted queued state, starting at a random index
        function logic [TASK_W-1:0] find_task(bit want_queued);
            int base;
            base = $urandom_range(TASKS - 1);
            for (int k = 0; k < TASKS; k++)
                if (queued[(base + k) % TASKS] == want_queued)
                    return TASK_W'((base + k) % TASKS);
            return TASK_W'(base);
        endfunction

        // Remove a queued task from anywhere in its level's list
        function void unlink_task(logic [TASK_W-1:0] t);
            logic [PRIO_W-1:0] lv;
            logic [TASK_W-1:0] nx, pv;
            bit at_head, at_tail;
            lv      = level_of[t];
            at_head = head_of[lv] == t;
            at_tail = tail_of[lv] == t;
            nx      = next_of[t];
            pv      = prev_of[t];
            if (at_head && at_tail)
            begin
                level_map[lv] = 1'b0;
            end
            else
            begin
                if (at_head)
                    head_of[lv] = nx;
                else
                    next_of[pv] = nx;
                if (at_tail)
                    tail_of[lv] = pv;
                else
                    prev_of[nx] = pv;
            end
            queued[t] = 1'b0;
            queued_count--;
        endfunction

        // Apply an accepted command and queue the result it must give
        function void note_command(req_t w);
            rsp_t want;
            int lv;
            want = '0;
            want.status = ST_OK;
            case (w.command)
                CMD_PUT:
                begin
                    n_put++;
                    if (queued[w.task_id])
                    begin
                        want.status = ST_QUEUED;
                    end
                    else
                    begin
                        if (level_map[w.priority_req])
                        begin
                            next_of[tail_of[w.priority_req]] = w.task_id;
                            prev_of[w.task_id] = tail_of[w.priority_req];
                        end
                        else
                        begin
                            head_of[w.priority_req] = w.task_id;
                            level_map[w.priority_req] = 1'b1;
                        end
                        tail_of[w.priority_req] = w.task_id;
                        level_of[w.task_id] = w.priority_req;
                        queued[w.task_id] = 1'b1;
                        queued_count++;
                        if (queued_count > peak_queued)
                            peak_queued = queued_count;
                    end
                end
                CMD_GET:
                begin
                    n_get++;
                    if (level_map == '0)
                    begin
                        want.status = ST_EMPTY;
                    end
                    else
                    begin
                        lv = 0;
                        while (!level_map[lv])
                            lv++;
                        want.task_out     = head_of[lv];
                        want.out_priority = PRIO_W'(lv);
                        unlink_task(head_of[lv]);
                    end
                end
                CMD_DEL:
                begin
                    n_del++;
                    if (!queued[w.task_id])
                        want.status = ST_NOT_QUEUED;
                    else
                        unlink_task(w.task_id);
                end
                default: n_nop++;
            endcase
            if (want.status != ST_OK)
                n_rejected++;
            want.nonempty_levels = level_map;
            pending_results.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
                errors++;
            end
        endfunction

        // Compare one result word with the oldest expectation
        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %0h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("task_out", 32'(want.task_out), 32'(got.task_out));
            compare_field("out_priority", 32'(want.out_priority), 32'(got.out_priority));
            compare_field("nonempty_levels", want.nonempty_levels, got.nonempty_levels);
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    run_queue_scoreboard sb;
    int idle_cycles = 0;
    int idle_pct [3] = '{20, 48, 0};

    bitmap_priority_run_queue #(
        .LEVELS(LEVELS),
        .TASKS (TASKS)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .req  (req),
        .busy (busy),
        .done (done),
        .rsp  (rsp)
    );

    always #6 clk = ~clk;

    // Check every result word as it is strobed
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(rsp);
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, sb.pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic req_t command_word(cmd_t c, int t, int p);
        req_t w;
        w.command      = c;
        w.task_id      = TASK_W'(t);
        w.priority_req = PRIO_W'(p);
        return w;
    endfunction

    // Build a random command; puts mostly pick unqueued tasks, deletes mostly queued ones
    function automatic req_t random_command(int put_weight);
        req_t w;
        int roll;
        roll           = $urandom_range(99);
        w.task_id      = TASK_W'($urandom_range(TASKS - 1));
        w.priority_req = PRIO_W'($urandom_range(31));
        if (roll < 3)
        begin
            w.command = CMD_NOP;
        end
        else if (roll < put_weight)
        begin
            w.command = CMD_PUT;
            if ($urandom_range(99) < 85)
                w.task_id = sb.find_task(1'b0);
            if ($urandom_range(99) < 70)
                w.priority_req = PRIO_W'($urandom_range(3));
        end
        else if (roll < put_weight + (100 - put_weight) / 2)
        begin
            w.command = CMD_GET;
        end
        else
        begin
            w.command = CMD_DEL;
            if ($urandom_range(99) < 80)
                w.task_id = sb.find_task(1'b1);
        end
        return w;
    endfunction

    // Offer one command word, with an optional idle gap first, and wait for acceptance
    task automatic send_command(req_t w, int gap_pct);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        req   <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(w);
    endtask

    initial
    begin
        int put_weight;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue, rejects, extreme ids and levels, mid-list delete
        send_command(command_word(CMD_GET, 63, 31), 0);
        send_command(command_word(CMD_DEL, 0, 0), 0);
        send_command(command_word(CMD_PUT, 0, 0), 0);
        send_command(command_word(CMD_PUT, 63, 31), 0);
        send_command(command_word(CMD_PUT, 0, 5), 0);
        send_command(command_word(CMD_PUT, 5, 31), 0);
        send_command(command_word(CMD_PUT, 6, 31), 0);
        send_command(command_word(CMD_PUT, 7, 31), 0);
        send_command(command_word(CMD_DEL, 6, 0), 0);
        send_command(command_word(CMD_DEL, 63, 0), 0);
        send_command(command_word(CMD_DEL, 7, 0), 0);
        send_command(command_word(CMD_PUT, 63, 31), 0);
        send_command(command_word(CMD_NOP, 42, 21), 0);
        send_command(command_word(CMD_PUT, 42, 17), 0);
        send_command(command_word(CMD_GET, 0, 0), 0);
        send_command(command_word(CMD_GET, 0, 0), 0);
        send_command(command_word(CMD_GET, 0, 0), 0);
        send_command(command_word(CMD_DEL, 63, 0), 0);
        send_command(command_word(CMD_GET, 0, 0), 0);
        send_command(command_word(CMD_GET, 0, 0), 0);
        send_command(command_word(CMD_DEL, 63, 31), 0);
        send_command(command_word(CMD_PUT, 21, 10), 0);
        send_command(command_word(CMD_DEL, 21, 0), 0);

        // Random phases: sender idles now and then, then more often, then never
        put_weight = 50;
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 50 == 0)
                    put_weight = $urandom_range(30, 75);
                send_command(random_command(put_weight), idle_pct[phase]);
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then allow for stray strobes
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d commands: %0d put, %0d get, %0d delete, %0d unused code, %0d rejected",
                 sb.n_put + sb.n_get + sb.n_del + sb.n_nop, sb.n_put, sb.n_get, sb.n_del,
                 sb.n_nop, sb.n_rejected);
        $display("At most %0d tasks were queued at once; %0d mismatches", sb.peak_queued,
                 sb.errors);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bprq_pkg.sv
rtl/core/bprq_ram.sv
rtl/core/bitmap_priority_run_queue.sv
rtl/core/bprq_chk.sv
dv/tb_bitmap_priority_run_queue.sv
